FILE: sv/lfsa_pkg.sv
// shared widths, codes and field layout of the lowest free slot allocator
package lfsa_pkg;

  localparam int unsigned ID_W       = 11;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned SLOT_FLD_W = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CHARGE_W   = 48;
  localparam int unsigned PROD_W     = WEIGHT_W + RATE_W;
  localparam int unsigned ENTRY_W    = WEIGHT_W + ID_W;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD_RATE = 2'd0,
    OP_ARRIVE    = 2'd1,
    OP_DEPART    = 2'd2
  } op_e;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT    = 2'd2;

endpackage

FILE: sv/lowest_free_slot_allocator.sv
// a request is captured and its memories read; in the execute state the result is registered
//   when the output is free, and only then is a new request taken, after the synchronous read
//   of the requester-slot and wait-queue memories and the read-modify-write that follows it
// reset: slot busy flags, slot rates, queue pointers and the charge sum clear at once;
//   the requester-slot and wait-queue memories keep their contents, no clearing pass
module lowest_free_slot_allocator #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned REQUESTERS = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // requester_id[10:0], requester_weight[26:11], slot_number[30:27], rate_value[46:31]
  input  logic [lfsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // placed[0], placed_slot[4:1], placed_requester[15:5], was_queued[16], status[18:17],
  // total_charge[66:19]
  output logic [lfsa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int unsigned CW = $clog2(REQUESTERS + 1);
  localparam logic [RW-1:0] HEAD_LAST = RW'(REQUESTERS - 1);
  localparam logic [CW-1:0] QUEUE_CAP = CW'(REQUESTERS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // request capture
  logic [1:0]                    op_q;
  logic [lfsa_pkg::ID_W-1:0]     id_q;
  logic [lfsa_pkg::WEIGHT_W-1:0] weight_q;
  logic [lfsa_pkg::SLOT_FLD_W-1:0] sn_q;
  logic [lfsa_pkg::RATE_W-1:0]   rate_in_q;

  // small slot state
  logic [SLOTS-1:0]              busy_q, busy_d;
  logic [lfsa_pkg::ID_W-1:0]     holder_q [SLOTS];
  logic [lfsa_pkg::RATE_W-1:0]   rate_q   [SLOTS];

  // queue pointers and charge
  logic [RW-1:0]                 head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [lfsa_pkg::CHARGE_W-1:0] charge_q, charge_d;

  // memories
  logic [SW-1:0]                 rs_mem [REQUESTERS];
  logic [lfsa_pkg::ENTRY_W-1:0]  wq_mem [REQUESTERS];
  logic [SW-1:0]                 rs_rdata_q;
  logic [lfsa_pkg::ENTRY_W-1:0]  wq_rdata_q;

  logic                          rs_we;
  logic [RW-1:0]                 rs_waddr;
  logic [SW-1:0]                 rs_wdata;
  logic                          wq_we;
  logic                          hold_we;
  logic [SW-1:0]                 hold_idx;
  logic [lfsa_pkg::ID_W-1:0]     hold_val;
  logic                          rate_we;

  // output register
  logic                          out_valid_q;
  logic                          placed_q, placed_d;
  logic [SW-1:0]                 pslot_q, pslot_d;
  logic [lfsa_pkg::ID_W-1:0]     preq_q, preq_d;
  logic                          queued_q, queued_d;
  logic [lfsa_pkg::STATUS_W-1:0] status_q, status_d;

  logic                          accept;
  logic                          commit;
  logic                          free_found;
  logic [SW-1:0]                 free_slot;
  logic                          id_ok;
  logic                          dep_ok;
  logic [lfsa_pkg::ID_W-1:0]     nid;
  logic                          chg_en;
  logic [lfsa_pkg::WEIGHT_W-1:0] chg_w;
  logic [SW-1:0]                 chg_slot;
  logic [lfsa_pkg::PROD_W-1:0]   prod;
  logic [lfsa_pkg::CHARGE_W-1:0] room;
  logic [RW-1:0]                 head_inc, tail_inc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;

  lfsa_find_free #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_find_free (
    .busy_i  (busy_q),
    .found_o (free_found),
    .slot_o  (free_slot)
  );

  assign id_ok    = 32'(id_q) < REQUESTERS;
  assign head_inc = (head_q == HEAD_LAST) ? '0 : head_q + RW'(1);
  assign tail_inc = (tail_q == HEAD_LAST) ? '0 : tail_q + RW'(1);
  assign nid      = wq_rdata_q[lfsa_pkg::ID_W-1:0];
  // a stored slot is trusted only when that slot is busy and held by this id
  assign dep_ok   = id_ok && (32'(rs_rdata_q) < SLOTS) && busy_q[rs_rdata_q]
                    && (holder_q[rs_rdata_q] == id_q);

  always_comb begin
    busy_d   = busy_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    rs_we    = 1'b0;
    rs_waddr = RW'(id_q);
    rs_wdata = free_slot;
    wq_we    = 1'b0;
    hold_we  = 1'b0;
    hold_idx = free_slot;
    hold_val = id_q;
    rate_we  = 1'b0;
    chg_en   = 1'b0;
    chg_w    = weight_q;
    chg_slot = free_slot;
    placed_d = 1'b0;
    pslot_d  = '0;
    preq_d   = '0;
    queued_d = 1'b0;
    status_d = lfsa_pkg::STATUS_OK;
    unique case (op_q)
      lfsa_pkg::OP_LOAD_RATE: begin
        rate_we = 32'(sn_q) < SLOTS;
      end
      lfsa_pkg::OP_ARRIVE: begin
        if (id_ok) begin
          priority if (free_found) begin
            busy_d[free_slot] = 1'b1;
            hold_we  = 1'b1;
            rs_we    = 1'b1;
            chg_en   = 1'b1;
            placed_d = 1'b1;
            pslot_d  = free_slot;
            preq_d   = id_q;
          end else if (count_q >= QUEUE_CAP) begin
            status_d = lfsa_pkg::STATUS_QUEUE_FULL;
          end else begin
            wq_we    = 1'b1;
            tail_d   = tail_inc;
            count_d  = count_q + CW'(1);
            queued_d = 1'b1;
          end
        end
      end
      lfsa_pkg::OP_DEPART: begin
        if (dep_ok) begin
          busy_d[rs_rdata_q] = 1'b0;
          if (count_q != '0) begin
            head_d  = head_inc;
            count_d = count_q - CW'(1);
            // hand the freed slot straight to the queue head
            if (32'(nid) < REQUESTERS) begin
              busy_d[rs_rdata_q] = 1'b1;
              hold_we  = 1'b1;
              hold_idx = rs_rdata_q;
              hold_val = nid;
              rs_we    = 1'b1;
              rs_waddr = RW'(nid);
              rs_wdata = rs_rdata_q;
              chg_en   = 1'b1;
              chg_w    = wq_rdata_q[lfsa_pkg::ENTRY_W-1:lfsa_pkg::ID_W];
              chg_slot = rs_rdata_q;
              placed_d = 1'b1;
              pslot_d  = rs_rdata_q;
              preq_d   = nid;
            end
          end
        end else begin
          status_d = lfsa_pkg::STATUS_NO_SLOT;
        end
      end
      default: begin
      end
    endcase
  end

  // saturating charge accumulate
  always_comb begin
    prod     = chg_w * rate_q[chg_slot];
    room     = lfsa_pkg::CHARGE_MAX - charge_q;
    charge_d = charge_q;
    if (chg_en) begin
      if (lfsa_pkg::CHARGE_W'(prod) > room) begin
        charge_d = lfsa_pkg::CHARGE_MAX;
      end else begin
        charge_d = charge_q + lfsa_pkg::CHARGE_W'(prod);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      charge_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q     <= S_IDLE;
            busy_q      <= busy_d;
            head_q      <= head_d;
            tail_q      <= tail_d;
            count_q     <= count_d;
            charge_q    <= charge_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= s_axis_tuser;
      id_q      <= s_axis_tdata[10:0];
      weight_q  <= s_axis_tdata[26:11];
      sn_q      <= s_axis_tdata[30:27];
      rate_in_q <= s_axis_tdata[46:31];
    end
    if (commit) begin
      placed_q <= placed_d;
      pslot_q  <= pslot_d;
      preq_q   <= preq_d;
      queued_q <= queued_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        rate_q[i] <= '0;
      end
    end else if (commit && rate_we) begin
      rate_q[SW'(sn_q)] <= rate_in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && hold_we) begin
      holder_q[hold_idx] <= hold_val;
    end
  end

  // requester-slot memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rs_rdata_q <= rs_mem[RW'(s_axis_tdata[10:0])];
    end
    if (commit && rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
  end

  // wait-queue memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wq_rdata_q <= wq_mem[head_q];
    end
    if (commit && wq_we) begin
      wq_mem[tail_q] <= {weight_q, id_q};
    end
  end

  assign m_axis_tdata = {
    5'd0,
    charge_q,
    status_q,
    queued_q,
    preq_q,
    lfsa_pkg::SLOT_FLD_W'(pslot_q),
    placed_q
  };

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CAP)
    else $error("wait queue count beyond capacity");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_placed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && placed_q) |-> busy_q[pslot_q])
    else $error("placed slot is not marked busy");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_charge_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (charge_q >= $past(charge_q)))
    else $error("charge sum decreased");

endmodule

FILE: sv/lfsa_find_free.sv
// priority encoder that picks the lowest-numbered free slot
module lfsa_find_free #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0] busy_i,
  output logic             found_o,
  output logic [SW-1:0]    slot_o
);

  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    // scan downward so the lowest free index wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_i[i]) begin
        found_o = 1'b1;
        slot_o  = SW'(i);
      end
    end
  end

endmodule

FILE: tb/sv/lowest_free_slot_allocator_tb.sv
// self-checking testbench of the lowest free slot allocator with in-order result checking
module lowest_free_slot_allocator_tb;

  localparam int SLOTS      = 16;
  localparam int REQUESTERS = 2048;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                      opcode;
    logic [lfsa_pkg::RATE_W-1:0]     rate;
    logic [lfsa_pkg::SLOT_FLD_W-1:0] slot;
    logic [lfsa_pkg::WEIGHT_W-1:0]   weight;
    logic [lfsa_pkg::ID_W-1:0]       id;
  } request_t;

  // same order as the result word, placed in the lowest bit
  typedef struct packed {
    logic [lfsa_pkg::CHARGE_W-1:0]   charge;
    logic [lfsa_pkg::STATUS_W-1:0]   status;
    logic                            queued;
    logic [lfsa_pkg::ID_W-1:0]       requester;
    logic [lfsa_pkg::SLOT_FLD_W-1:0] slot;
    logic                            placed;
  } grant_t;

  typedef struct packed {
    request_t req;
    grant_t   grant;
  } planned_request_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lfsa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]                      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lfsa_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  lowest_free_slot_allocator #(
    .SLOTS      (SLOTS),
    .REQUESTERS (REQUESTERS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // allocator state as predicted
  bit                              slot_taken       [SLOTS];
  bit [lfsa_pkg::ID_W-1:0]         slot_owner       [SLOTS];
  bit [lfsa_pkg::RATE_W-1:0]       slot_price       [SLOTS];
  bit [lfsa_pkg::SLOT_FLD_W-1:0]   owner_slot       [REQUESTERS];
  bit                              owner_slot_valid [REQUESTERS];
  bit [lfsa_pkg::ENTRY_W-1:0]      waiting_line     [REQUESTERS];
  bit [lfsa_pkg::ID_W-1:0]         line_head;
  bit [lfsa_pkg::ID_W-1:0]         line_tail;
  int                              line_len;
  bit [lfsa_pkg::CHARGE_W-1:0]     charge_total;

  // stimulus bookkeeping
  int                              in_line_copies   [REQUESTERS];
  longint                          grant_order      [SLOTS];
  longint                          grant_seq;
  grant_t                          last_grant;

  planned_request_t                requests_to_send [$];
  grant_t                          grants_due       [$];
  planned_request_t                next_up;
  grant_t                          grant_on_bus;
  grant_t                          seen;
  grant_t                          owed;
  int                              requests_planned;
  int                              results_seen;
  int                              mismatches;
  int unsigned                     send_idle_pct = 10;
  int unsigned                     take_idle_pct = 56;

  function automatic void hand_slot(bit [lfsa_pkg::SLOT_FLD_W-1:0] s,
                                    bit [lfsa_pkg::ID_W-1:0] id,
                                    bit [lfsa_pkg::WEIGHT_W-1:0] w);
    bit [lfsa_pkg::PROD_W-1:0] prod;
    prod = w * slot_price[s];
    slot_taken[s] = 1'b1;
    slot_owner[s] = id;
    owner_slot[id] = s;
    owner_slot_valid[id] = 1'b1;
    if (prod > lfsa_pkg::CHARGE_MAX - charge_total) charge_total = lfsa_pkg::CHARGE_MAX;
    else charge_total = charge_total + prod;
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    bit found;
    bit [lfsa_pkg::SLOT_FLD_W-1:0] pick;
    bit [lfsa_pkg::ENTRY_W-1:0] head_entry;
    int s;
    g = '0;
    found = 1'b0;
    pick = '0;
    case (r.opcode)
      lfsa_pkg::OP_LOAD_RATE: slot_price[r.slot] = r.rate;
      lfsa_pkg::OP_ARRIVE: begin
        for (s = SLOTS - 1; s >= 0; s--) begin
          if (!slot_taken[s]) begin
            found = 1'b1;
            pick = lfsa_pkg::SLOT_FLD_W'(s);
          end
        end
        if (found) begin
          hand_slot(pick, r.id, r.weight);
          g.placed = 1'b1;
          g.slot = pick;
          g.requester = r.id;
        end else if (line_len >= REQUESTERS) begin
          g.status = lfsa_pkg::STATUS_QUEUE_FULL;
        end else begin
          waiting_line[line_tail] = {r.weight, r.id};
          line_tail++;
          line_len++;
          g.queued = 1'b1;
        end
      end
      lfsa_pkg::OP_DEPART: begin
        pick = owner_slot[r.id];
        if (owner_slot_valid[r.id] && slot_taken[pick] && slot_owner[pick] == r.id) begin
          slot_taken[pick] = 1'b0;
          if (line_len > 0) begin
            // freed slot goes straight to the head of the line
            head_entry = waiting_line[line_head];
            line_head++;
            line_len--;
            hand_slot(pick, head_entry[lfsa_pkg::ID_W-1:0],
                      head_entry[lfsa_pkg::ENTRY_W-1:lfsa_pkg::ID_W]);
            g.placed = 1'b1;
            g.slot = pick;
            g.requester = head_entry[lfsa_pkg::ID_W-1:0];
          end
        end else begin
          g.status = lfsa_pkg::STATUS_NO_SLOT;
        end
      end
      default: ;
    endcase
    g.charge = charge_total;
    return g;
  endfunction

  function automatic bit [15:0] biased_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_request(input logic [1:0] op, input bit [lfsa_pkg::ID_W-1:0] id,
                               input bit [lfsa_pkg::WEIGHT_W-1:0] w,
                               input bit [lfsa_pkg::SLOT_FLD_W-1:0] sn,
                               input bit [lfsa_pkg::RATE_W-1:0] rate);
    planned_request_t e;
    e.req.opcode = op;
    e.req.id = id;
    e.req.weight = w;
    e.req.slot = sn;
    e.req.rate = rate;
    e.grant = predict_grant(e.req);
    last_grant = e.grant;
    if (e.grant.queued) in_line_copies[id]++;
    if (e.grant.placed) begin
      grant_order[e.grant.slot] = grant_seq;
      grant_seq++;
      if (op == lfsa_pkg::OP_DEPART) in_line_copies[e.grant.requester]--;
    end
    requests_to_send.push_back(e);
    requests_planned++;
  endtask

  // mostly well-formed: arrivals of ids that neither hold a slot nor wait, releases of holders
  task automatic queue_random_request();
    int pick;
    int k;
    int base;
    bit [lfsa_pkg::ID_W-1:0] who;
    bit found;
    pick = $urandom_range(0, 99);
    found = 1'b0;
    who = '0;
    if (pick >= 50) begin
      if ($urandom_range(0, 9) == 0) begin
        // stale release: an id that was placed once, may be gone or waiting
        for (k = 0; k < 8 && !found; k++) begin
          who = lfsa_pkg::ID_W'($urandom_range(0, 63));
          found = owner_slot_valid[who];
        end
      end
      base = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < SLOTS && !found; k++) begin
        if (slot_taken[(base + k) % SLOTS]) begin
          who = slot_owner[(base + k) % SLOTS];
          found = 1'b1;
        end
      end
      if (found) begin
        queue_request(lfsa_pkg::OP_DEPART, who, lfsa_pkg::WEIGHT_W'($urandom),
                      lfsa_pkg::SLOT_FLD_W'($urandom), lfsa_pkg::RATE_W'($urandom));
        return;
      end
      pick = $urandom_range(9, 49);
    end
    if (pick >= 9) begin
      for (k = 0; k < 8 && !found; k++) begin
        who = $urandom_range(0, 1) ? lfsa_pkg::ID_W'($urandom_range(0, 63))
                                   : lfsa_pkg::ID_W'($urandom_range(0, REQUESTERS - 1));
        found = in_line_copies[who] == 0 &&
                !(owner_slot_valid[who] && slot_taken[owner_slot[who]] &&
                  slot_owner[owner_slot[who]] == who);
      end
      if (found) begin
        queue_request(lfsa_pkg::OP_ARRIVE, who, biased_word(),
                      lfsa_pkg::SLOT_FLD_W'($urandom), lfsa_pkg::RATE_W'($urandom));
        return;
      end
      pick = 0;
    end
    if (pick >= 6) begin
      queue_request(OP_UNUSED, lfsa_pkg::ID_W'($urandom), lfsa_pkg::WEIGHT_W'($urandom),
                    lfsa_pkg::SLOT_FLD_W'($urandom), lfsa_pkg::RATE_W'($urandom));
    end else begin
      queue_request(lfsa_pkg::OP_LOAD_RATE, lfsa_pkg::ID_W'($urandom),
                    lfsa_pkg::WEIGHT_W'($urandom), lfsa_pkg::SLOT_FLD_W'($urandom),
                    biased_word());
    end
  endtask

  // release holders oldest first until every slot is free and the line is empty
  task automatic drain_all();
    int s;
    int oldest;
    forever begin
      oldest = -1;
      for (s = 0; s < SLOTS; s++) begin
        if (slot_taken[s] && (oldest < 0 || grant_order[s] < grant_order[oldest])) oldest = s;
      end
      if (oldest < 0) break;
      queue_request(lfsa_pkg::OP_DEPART, slot_owner[oldest], lfsa_pkg::WEIGHT_W'($urandom),
                    lfsa_pkg::SLOT_FLD_W'($urandom), lfsa_pkg::RATE_W'($urandom));
      if (last_grant.status != lfsa_pkg::STATUS_OK) break;
    end
  endtask

  task automatic wait_all_checked();
    while (results_seen < requests_planned) @(posedge clk_i);
  endtask

  task automatic report_grant_error(input string why, input grant_t want, input grant_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected placed=%0b slot=%0d requester=%0d queued=%0b status=%0d charge=%0d",
               why, want.placed, want.slot, want.requester, want.queued, want.status,
               want.charge,
               "\n  got placed=%0b slot=%0d requester=%0d queued=%0b status=%0d charge=%0d",
               got.placed, got.slot, got.requester, got.queued, got.status, got.charge);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      grant_on_bus <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_up = requests_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, next_up.req.rate, next_up.req.slot, next_up.req.weight,
                         next_up.req.id};
        s_axis_tuser <= next_up.req.opcode;
        grant_on_bus <= next_up.grant;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      // expectation enters the store when its request is taken
      if (s_axis_tvalid && s_axis_tready) grants_due.push_back(grant_on_bus);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = grant_t'(m_axis_tdata[$bits(grant_t)-1:0]);
        results_seen++;
        if (grants_due.size() == 0) begin
          report_grant_error("result with no request pending", '0, seen);
        end else begin
          owed = grants_due.pop_front();
          if (seen.placed !== owed.placed || seen.slot !== owed.slot ||
              seen.requester !== owed.requester || seen.queued !== owed.queued ||
              seen.status !== owed.status || seen.charge !== owed.charge)
            report_grant_error("wrong result", owed, seen);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(lfsa_pkg::OP_LOAD_RATE, 11'd0, 16'd0, 4'd0, 16'hFFFF);
    queue_request(lfsa_pkg::OP_LOAD_RATE, 11'h555, 16'hAAAA, 4'd15, 16'h8001);
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd0, 16'hFFFF, 4'd0, 16'd0);
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd2047, 16'd0, 4'hF, 16'hFFFF);
    // slot 2 still has a zero rate
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd5, 16'd1234, 4'd0, 16'd0);
    queue_request(OP_UNUSED, '1, '1, '1, '1);
    queue_request(lfsa_pkg::OP_DEPART, 11'd2047, 16'd0, 4'd0, 16'd0);
    queue_request(lfsa_pkg::OP_DEPART, 11'd2047, '1, '1, '1);
    for (k = 16; k < 30; k++) begin
      queue_request(lfsa_pkg::OP_ARRIVE, lfsa_pkg::ID_W'(k), biased_word(), '0, '0);
    end
    // every slot busy: this one waits, and a release attempt while waiting is refused
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd2047, 16'hFFFF, 4'd0, 16'd0);
    queue_request(lfsa_pkg::OP_DEPART, 11'd2047, 16'd0, 4'd0, 16'd0);
    queue_request(lfsa_pkg::OP_DEPART, 11'd0, 16'd0, 4'd0, 16'd0);
    repeat (530) queue_random_request();
    wait_all_checked();

    send_idle_pct = 56;
    take_idle_pct = 10;
    repeat (530) queue_random_request();
    drain_all();
    wait_all_checked();

    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (540) queue_random_request();
    drain_all();
    // an id that already holds a slot takes a second one; only the newer is released
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd50, biased_word(), '0, '0);
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd50, biased_word(), '0, '0);
    queue_request(lfsa_pkg::OP_DEPART, 11'd50, '0, '0, '0);
    queue_request(lfsa_pkg::OP_DEPART, 11'd50, '0, '0, '0);
    queue_request(lfsa_pkg::OP_ARRIVE, 11'd51, biased_word(), '0, '0);
    wait_all_checked();

    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && grants_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
